// ===== src/uxf_pkg.sv =====
// ----------------------------------------------------------------------------
// uxf_pkg
// Types and constants shared by the serial FIFO block with XON/XOFF flow
// control: event codes, flow phases, transfer payloads and control bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package uxf_pkg;

    localparam int RING_DEPTH_DEF = 16;
    localparam int LVL_W          = 5;

    localparam logic [LVL_W-1:0] XOFF_LEVEL_RST = LVL_W'(8);

    localparam logic [7:0] CH_XON   = 8'h11;
    localparam logic [7:0] CH_XOFF  = 8'h13;
    localparam logic [7:0] CH_RAW   = 8'h0E;
    localparam logic [7:0] CH_COOK  = 8'h0F;
    localparam logic [7:0] CH_ABORT = 8'h03;

    typedef enum logic [1:0] {
        CMD_LINE_RX = 2'd0,
        CMD_TX_DONE = 2'd1,
        CMD_HOST_RD = 2'd2,
        CMD_HOST_WR = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        FLOW_CLEAR  = 2'd0,
        FLOW_RUN    = 2'd1,
        FLOW_FILLED = 2'd2,
        FLOW_STOP   = 2'd3
    } flow_t;

    typedef struct packed {
        command_t   command;
        logic [7:0] data_byte;
    } uxf_in_t;

    typedef struct packed {
        logic       line_valid;
        logic [7:0] line_byte;
        logic       host_valid;
        logic [7:0] host_byte;
        logic       read_empty;
        logic       write_rejected;
        logic       rx_dropped;
        logic       abort_seen;
        logic       raw_flag;
        logic       send_paused;
        flow_t      flow_phase;
    } uxf_out_t;

endpackage

`default_nettype wire

// ===== src/uxf_ram.sv =====
// ----------------------------------------------------------------------------
// uxf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module uxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/uxf_ring_buf.sv =====
// ----------------------------------------------------------------------------
// uxf_ring_buf
// Ring FIFO storage: RAM plus a forwarding path so that a read of the entry
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module uxf_ring_buf #(
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [7:0]               wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [7:0]               rd_data
);

    logic       byp_hit_reg;
    logic [7:0] byp_data_reg;
    logic [7:0] ram_q;

    uxf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= wr_data;
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : ram_q;

endmodule

`default_nettype wire

// ===== src/uxf_ctrl.sv =====
// ----------------------------------------------------------------------------
// uxf_ctrl
// Event handling: FIFO pointers, flow phase, pause and raw flags, and the
// send decision for one registered event per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module uxf_ctrl
    import uxf_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire uxf_in_t                  item,
    input  wire logic [LVL_W-1:0]         xoff_level,
    input  wire logic [7:0]               rx_rd_data,
    input  wire logic [7:0]               tx_rd_data,
    output logic                          rx_wr_en,
    output logic      [$clog2(DEPTH)-1:0] rx_wr_addr,
    output logic      [$clog2(DEPTH)-1:0] rx_rd_addr,
    output logic                          tx_wr_en,
    output logic      [$clog2(DEPTH)-1:0] tx_wr_addr,
    output logic      [$clog2(DEPTH)-1:0] tx_rd_addr,
    output uxf_out_t                      result_next
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;
    localparam int CMP_W  = (FILL_W > LVL_W) ? FILL_W : LVL_W;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

    logic [ADDR_W-1:0] rx_head_reg, rx_head_next;
    logic [FILL_W-1:0] rx_fill_reg, rx_fill_next;
    logic [ADDR_W-1:0] tx_head_reg, tx_head_next;
    logic [FILL_W-1:0] tx_fill_reg, tx_fill_next;
    flow_t             flow_reg, flow_next;
    logic              paused_reg, paused_next;
    logic              raw_reg, raw_next;
    logic              tx_busy_reg, tx_busy_next;

    logic              send_try;
    logic              queue;
    logic [7:0]        tx_pop_data;
    uxf_out_t          res;

    function automatic logic [ADDR_W-1:0] idx_inc(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] r;
        if (idx == ADDR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = ADDR_W'(idx + 1'b1);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] idx_add(input logic [ADDR_W-1:0] head,
                                                 input logic [FILL_W-1:0] fill);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(fill);
        if (s >= SUM_W'(DEPTH))
        begin
            s = SUM_W'(s - SUM_W'(DEPTH));
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic flow_t flow_adv(input flow_t f);
        flow_t r;
        unique case (f)
            FLOW_CLEAR:  r = FLOW_RUN;
            FLOW_RUN:    r = FLOW_FILLED;
            FLOW_FILLED: r = FLOW_STOP;
            FLOW_STOP:   r = FLOW_CLEAR;
            default:     r = FLOW_CLEAR;
        endcase
        return r;
    endfunction

    assign rx_wr_addr = idx_add(rx_head_reg, rx_fill_reg);
    assign tx_wr_addr = idx_add(tx_head_reg, tx_fill_reg);
    assign rx_rd_addr = rx_head_next;
    assign tx_rd_addr = tx_head_next;

    always_comb
    begin
        rx_head_next = rx_head_reg;
        rx_fill_next = rx_fill_reg;
        tx_head_next = tx_head_reg;
        tx_fill_next = tx_fill_reg;
        flow_next    = flow_reg;
        paused_next  = paused_reg;
        raw_next     = raw_reg;
        tx_busy_next = tx_busy_reg;
        rx_wr_en     = 1'b0;
        tx_wr_en     = 1'b0;
        send_try     = 1'b0;
        queue        = 1'b0;
        tx_pop_data  = tx_rd_data;
        res          = '0;

        if (in_valid)
        begin
            unique case (item.command)
                CMD_LINE_RX:
                begin
                    queue = 1'b1;
                    if (item.data_byte == CH_ABORT)
                    begin
                        res.abort_seen = 1'b1;
                    end
                    else if (item.data_byte == CH_RAW)
                    begin
                        raw_next = 1'b1;
                        queue    = 1'b0;
                    end
                    else if (item.data_byte == CH_COOK)
                    begin
                        raw_next = 1'b0;
                        queue    = 1'b0;
                    end
                    else if (item.data_byte == CH_XOFF)
                    begin
                        paused_next = 1'b1;
                        queue       = 1'b0;
                    end
                    else if (item.data_byte == CH_XON)
                    begin
                        paused_next = 1'b0;
                        send_try    = 1'b1;
                        queue       = 1'b0;
                    end
                    if (queue)
                    begin
                        if (rx_fill_reg < FILL_FULL)
                        begin
                            rx_wr_en     = 1'b1;
                            rx_fill_next = FILL_W'(rx_fill_reg + 1'b1);
                        end
                        else
                        begin
                            res.rx_dropped = 1'b1;
                        end
                        if ((flow_reg == FLOW_RUN) &&
                            (CMP_W'(rx_fill_next) >= CMP_W'(xoff_level)))
                        begin
                            flow_next = FLOW_FILLED;
                            send_try  = 1'b1;
                        end
                    end
                end
                CMD_TX_DONE:
                begin
                    tx_busy_next = 1'b0;
                    send_try     = 1'b1;
                    if ((flow_reg == FLOW_STOP) && (rx_fill_reg == '0))
                    begin
                        flow_next = FLOW_CLEAR;
                    end
                end
                CMD_HOST_RD:
                begin
                    if (rx_fill_reg != '0)
                    begin
                        res.host_valid = 1'b1;
                        res.host_byte  = rx_rd_data;
                        rx_head_next   = idx_inc(rx_head_reg);
                        rx_fill_next   = FILL_W'(rx_fill_reg - 1'b1);
                        if ((flow_reg == FLOW_STOP) && (rx_fill_next == '0))
                        begin
                            flow_next = FLOW_CLEAR;
                            send_try  = 1'b1;
                        end
                    end
                    else
                    begin
                        res.read_empty = 1'b1;
                    end
                end
                CMD_HOST_WR:
                begin
                    if (tx_fill_reg < FILL_FULL)
                    begin
                        tx_wr_en     = 1'b1;
                        tx_fill_next = FILL_W'(tx_fill_reg + 1'b1);
                        send_try     = 1'b1;
                        if (tx_fill_reg == '0)
                        begin
                            tx_pop_data = item.data_byte;
                        end
                    end
                    else
                    begin
                        res.write_rejected = 1'b1;
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase

            if (send_try && !tx_busy_next && !paused_next)
            begin
                if ((flow_next == FLOW_CLEAR) || (flow_next == FLOW_FILLED))
                begin
                    flow_next      = flow_adv(flow_next);
                    res.line_valid = 1'b1;
                    res.line_byte  = (flow_next == FLOW_RUN) ? CH_XON : CH_XOFF;
                    tx_busy_next   = 1'b1;
                end
                else if (tx_fill_next != '0)
                begin
                    res.line_valid = 1'b1;
                    res.line_byte  = tx_pop_data;
                    tx_head_next   = idx_inc(tx_head_reg);
                    tx_fill_next   = FILL_W'(tx_fill_next - 1'b1);
                    tx_busy_next   = 1'b1;
                end
            end
        end

        res.raw_flag    = raw_next;
        res.send_paused = paused_next;
        res.flow_phase  = flow_next;
        result_next     = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg <= '0;
            rx_fill_reg <= '0;
            tx_head_reg <= '0;
            tx_fill_reg <= '0;
            flow_reg    <= FLOW_CLEAR;
            paused_reg  <= 1'b0;
            raw_reg     <= 1'b0;
            tx_busy_reg <= 1'b0;
        end
        else
        begin
            rx_head_reg <= rx_head_next;
            rx_fill_reg <= rx_fill_next;
            tx_head_reg <= tx_head_next;
            tx_fill_reg <= tx_fill_next;
            flow_reg    <= flow_next;
            paused_reg  <= paused_next;
            raw_reg     <= raw_next;
            tx_busy_reg <= tx_busy_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fill_reg <= FILL_FULL) && (tx_fill_reg <= FILL_FULL))
        else $error("ring fill count beyond depth");

    a_send_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && result_next.line_valid && (item.command != CMD_TX_DONE))
            |-> !tx_busy_reg)
        else $error("transfer to transmitter while it is busy");

    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && result_next.line_valid) |=> tx_busy_reg)
        else $error("transmitter not marked busy after a send");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && result_next.host_valid) |=>
            (rx_fill_reg == FILL_W'($past(rx_fill_reg) - 1'b1)))
        else $error("host read did not drop receive fill by one");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |=> ($stable(rx_fill_reg) && $stable(tx_fill_reg) && $stable(flow_reg)))
        else $error("state changed without an event");
`endif

endmodule

`default_nettype wire

// ===== src/uart_fifo_xon_xoff_flow.sv =====
// Start is captured in the input register, then done and the result in the
// done and result registers; both are taken at the edge ending the done cycle.
// Throughput: one event per cycle; busy is low in every cycle but the first
// after reset, and the receiver takes each result in its single done cycle.
// Reset: both rings empty, flow phase clear (XON goes out at the first send),
// not paused, raw mode off, transmitter idle, XOFF level 8.
// ----------------------------------------------------------------------------
// uart_fifo_xon_xoff_flow
// Receive and transmit ring FIFOs with XON/XOFF software flow control:
// input register, event logic with ring storage, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_fifo_xon_xoff_flow
    import uxf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire uxf_in_t          item,
    output logic                  done,
    output uxf_out_t              result,
    input  wire logic             cfg_we,
    input  wire logic [LVL_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(RING_DEPTH);

    logic             busy_reg;
    logic             in_valid_reg;
    uxf_in_t          in_item_reg;
    logic             done_reg;
    uxf_out_t         result_reg;
    uxf_out_t         result_next;
    logic [LVL_W-1:0] xoff_level_reg;

    logic              rx_wr_en, tx_wr_en;
    logic [ADDR_W-1:0] rx_wr_addr, rx_rd_addr, tx_wr_addr, tx_rd_addr;
    logic [7:0]        rx_rd_data, tx_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            in_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
            xoff_level_reg <= XOFF_LEVEL_RST;
        end
        else
        begin
            busy_reg     <= 1'b0;
            in_valid_reg <= start && !busy_reg;
            done_reg     <= in_valid_reg;
            if (cfg_we)
            begin
                xoff_level_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            in_item_reg <= item;
        end
        result_reg <= result_next;
    end

    uxf_ring_buf #(
        .DEPTH (RING_DEPTH)
    ) u_rx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (in_item_reg.data_byte),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    uxf_ring_buf #(
        .DEPTH (RING_DEPTH)
    ) u_tx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (in_item_reg.data_byte),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    uxf_ctrl #(
        .DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid_reg),
        .item        (in_item_reg),
        .xoff_level  (xoff_level_reg),
        .rx_rd_data  (rx_rd_data),
        .tx_rd_data  (tx_rd_data),
        .rx_wr_en    (rx_wr_en),
        .rx_wr_addr  (rx_wr_addr),
        .rx_rd_addr  (rx_rd_addr),
        .tx_wr_en    (tx_wr_en),
        .tx_wr_addr  (tx_wr_addr),
        .tx_rd_addr  (tx_rd_addr),
        .result_next (result_next)
    );

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
